// File: rtl/core/mm5_pkg.sv
// shared constants and types for the 5x5 integer matrix multiplier
// no dependencies; used by matrix_multiply_5x5 and mm5_mac in rtl/core
package mm5_pkg;

    localparam int DIM    = 5;
    localparam int CELLS  = DIM * DIM;
    localparam int ELEM_W = 16;
    localparam int MUL_W  = 2 * ELEM_W;
    localparam int PROD_W = 35;
    localparam int ROW_W  = 3;
    localparam int IDX_W  = $clog2(DIM);
    localparam int CELL_W = $clog2(CELLS);
    localparam int LOAD_W = $clog2(2 * CELLS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } mm5_state_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// File: rtl/core/matrix_multiply_5x5.sv
// top level of the 5x5 integer matrix multiplier
// depends on mm5_pkg, mm5_ram and mm5_mac
//
// usage:
//   s_ channel: 50 transactions of s_element_value, matrix A then matrix B,
//   each row-major, signed 16 bit. loading takes one element per cycle while s_valid is high.
//   m_ channel: after the last element of B, 25 results of C = A * B come out
//   row-major with m_row_index, m_col_index, exact signed 35-bit
//   m_product_value, and m_last_result on the final one.
//   each result is a dot product run on one shared multiply-accumulate unit
//   fed by the A and B memories: DIM element pairs are issued, each passes
//   the memory read, multiply and accumulate registers, then the result sits
//   in the output until taken; the next result is not started before then.
//   a full run loads 50 elements, then computes 25 results.
//   s_ready is high only while loading; a new load starts once the last
//   result is taken. when the receiver stalls, the current result holds
//   and computation pauses. reset returns the block to an empty load.
module matrix_multiply_5x5 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mm5_pkg::ELEM_W-1:0] s_element_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mm5_pkg::ROW_W-1:0]         m_row_index,
    output logic [mm5_pkg::ROW_W-1:0]         m_col_index,
    output logic signed [mm5_pkg::PROD_W-1:0] m_product_value,
    output logic                              m_last_result
);

    mm5_pkg::mm5_state_t            state_reg, state_next;
    logic [mm5_pkg::LOAD_W-1:0]     load_cnt_reg, load_cnt_next;
    logic [mm5_pkg::IDX_W-1:0]      i_reg, i_next;
    logic [mm5_pkg::IDX_W-1:0]      j_reg, j_next;
    logic [mm5_pkg::IDX_W-1:0]      k_reg, k_next;
    logic [mm5_pkg::CELL_W-1:0]     row_base_reg, row_base_next;
    logic [mm5_pkg::CELL_W-1:0]     a_addr_reg, a_addr_next;
    logic [mm5_pkg::CELL_W-1:0]     b_addr_reg, b_addr_next;
    mm5_pkg::mac_ctl_t              rd_ctl_reg;
    mm5_pkg::mac_ctl_t              issue_ctl;

    logic                           a_we;
    logic                           b_we;
    logic [mm5_pkg::CELL_W-1:0]     b_wr_addr;
    logic [mm5_pkg::ELEM_W-1:0]     a_rd_data;
    logic [mm5_pkg::ELEM_W-1:0]     b_rd_data;
    logic signed [mm5_pkg::PROD_W-1:0] mac_acc;
    logic                           mac_done;
    logic                           in_fire;
    logic                           last_row;
    logic                           last_col;

    assign s_ready  = (state_reg == mm5_pkg::ST_LOAD);
    assign in_fire  = s_valid && s_ready;
    assign last_row = (i_reg == mm5_pkg::IDX_W'(mm5_pkg::DIM - 1));
    assign last_col = (j_reg == mm5_pkg::IDX_W'(mm5_pkg::DIM - 1));

    assign a_we      = in_fire && (load_cnt_reg < mm5_pkg::LOAD_W'(mm5_pkg::CELLS));
    assign b_we      = in_fire && (load_cnt_reg >= mm5_pkg::LOAD_W'(mm5_pkg::CELLS));
    assign b_wr_addr = mm5_pkg::CELL_W'(load_cnt_reg - mm5_pkg::LOAD_W'(mm5_pkg::CELLS));

    mm5_ram #(
        .DEPTH (mm5_pkg::CELLS),
        .WIDTH (mm5_pkg::ELEM_W)
    ) u_a_ram (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (mm5_pkg::CELL_W'(load_cnt_reg)),
        .wr_data (s_element_value),
        .rd_addr (a_addr_reg),
        .rd_data (a_rd_data)
    );

    mm5_ram #(
        .DEPTH (mm5_pkg::CELLS),
        .WIDTH (mm5_pkg::ELEM_W)
    ) u_b_ram (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_wr_addr),
        .wr_data (s_element_value),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd_data)
    );

    mm5_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rd_ctl_reg),
        .a       (a_rd_data),
        .b       (b_rd_data),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    always_comb begin
        issue_ctl.vld   = (state_reg == mm5_pkg::ST_ISSUE);
        issue_ctl.first = (k_reg == '0);
        issue_ctl.last  = (k_reg == mm5_pkg::IDX_W'(mm5_pkg::DIM - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mm5_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
            rd_ctl_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            row_base_reg <= row_base_next;
            a_addr_reg   <= a_addr_next;
            b_addr_reg   <= b_addr_next;
            rd_ctl_reg   <= issue_ctl;
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        row_base_next = row_base_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        case (state_reg)
            mm5_pkg::ST_LOAD: begin
                if (in_fire) begin
                    if (load_cnt_reg == mm5_pkg::LOAD_W'(2 * mm5_pkg::CELLS - 1)) begin
                        load_cnt_next = '0;
                        state_next    = mm5_pkg::ST_ISSUE;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            mm5_pkg::ST_ISSUE: begin
                a_addr_next = a_addr_reg + 1'b1;
                b_addr_next = b_addr_reg + mm5_pkg::CELL_W'(mm5_pkg::DIM);
                k_next      = k_reg + 1'b1;
                if (issue_ctl.last) begin
                    k_next     = '0;
                    state_next = mm5_pkg::ST_WAIT;
                end
            end
            mm5_pkg::ST_WAIT: begin
                if (mac_done) begin
                    state_next = mm5_pkg::ST_OUT;
                end
            end
            mm5_pkg::ST_OUT: begin
                if (m_ready) begin
                    if (last_col) begin
                        j_next      = '0;
                        b_addr_next = '0;
                        if (last_row) begin
                            i_next        = '0;
                            row_base_next = '0;
                            a_addr_next   = '0;
                            state_next    = mm5_pkg::ST_LOAD;
                        end else begin
                            i_next        = i_reg + 1'b1;
                            row_base_next = row_base_reg + mm5_pkg::CELL_W'(mm5_pkg::DIM);
                            a_addr_next   = row_base_reg + mm5_pkg::CELL_W'(mm5_pkg::DIM);
                            state_next    = mm5_pkg::ST_ISSUE;
                        end
                    end else begin
                        j_next      = j_reg + 1'b1;
                        a_addr_next = row_base_reg;
                        b_addr_next = mm5_pkg::CELL_W'(j_reg) + 1'b1;
                        state_next  = mm5_pkg::ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = mm5_pkg::ST_LOAD;
            end
        endcase
    end

    assign m_valid         = (state_reg == mm5_pkg::ST_OUT);
    assign m_row_index     = mm5_pkg::ROW_W'(i_reg);
    assign m_col_index     = mm5_pkg::ROW_W'(j_reg);
    assign m_product_value = mac_acc;
    assign m_last_result   = last_row && last_col;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output handshakes active together");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == mm5_pkg::ST_WAIT))
        else $error("accumulate finished outside of wait");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> s_ready && (load_cnt_reg == '0))
        else $error("block did not return to an empty load after the last result");

    a_load_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (load_cnt_reg == mm5_pkg::LOAD_W'(2 * mm5_pkg::CELLS - 1)))
        |=> (state_reg == mm5_pkg::ST_ISSUE) && (a_addr_reg == '0) && (b_addr_reg == '0))
        else $error("computation did not start at the first element");
`endif

endmodule

// File: rtl/core/mm5_ram.sv
// generic single-port-write, single-port-read memory with registered read data
// no dependencies
module mm5_ram #(
    parameter int DEPTH  = 25,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mm5_mac.sv
// multiply-accumulate unit: registered product, then exact 35-bit accumulate
// depends on mm5_pkg
module mm5_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mm5_pkg::mac_ctl_t                 ctl,
    input  logic signed [mm5_pkg::ELEM_W-1:0] a,
    input  logic signed [mm5_pkg::ELEM_W-1:0] b,
    output logic signed [mm5_pkg::PROD_W-1:0] acc,
    output logic                              done
);

    mm5_pkg::mac_ctl_t                 ctl_reg;
    logic signed [mm5_pkg::MUL_W-1:0]  prod_reg;
    logic signed [mm5_pkg::PROD_W-1:0] acc_reg;
    logic                              done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.vld && ctl_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        if (ctl_reg.vld) begin
            if (ctl_reg.first) begin
                acc_reg <= mm5_pkg::PROD_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + mm5_pkg::PROD_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: tb/sv/matrix_multiply_5x5_tb.sv
// testbench for matrix_multiply_5x5: loads A and B over the s_ channel and checks every C element
// on the m_ channel against a local row-by-column predictor; depends on mm5_pkg and the rtl only
module matrix_multiply_5x5_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_STALL  = 200;
    localparam int RAND_LOADS  = 3;
    localparam int STALL_AFTER = 40;

    typedef struct packed {
        logic [mm5_pkg::ROW_W-1:0]         row;
        logic [mm5_pkg::ROW_W-1:0]         col;
        logic signed [mm5_pkg::PROD_W-1:0] product;
        logic                              last;
    } product_t;

    typedef struct packed {
        logic signed [mm5_pkg::ELEM_W-1:0] a_fill;
        logic signed [mm5_pkg::ELEM_W-1:0] b_fill;
        logic                              alternate;
        logic                              typed;
        logic signed [mm5_pkg::PROD_W-1:0] product;
    } load_row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [mm5_pkg::ELEM_W-1:0]  s_element_value;
    logic                               m_valid;
    logic                               m_ready;
    logic [mm5_pkg::ROW_W-1:0]          m_row_index;
    logic [mm5_pkg::ROW_W-1:0]          m_col_index;
    logic signed [mm5_pkg::PROD_W-1:0]  m_product_value;
    logic                               m_last_result;

    logic signed [mm5_pkg::ELEM_W-1:0]  store_a [mm5_pkg::CELLS];
    logic signed [mm5_pkg::ELEM_W-1:0]  store_b [mm5_pkg::CELLS];
    int                                 load_pos = 0;
    logic                               load_typed;
    logic signed [mm5_pkg::PROD_W-1:0]  load_typed_val;
    logic                               typed_on = 1'b0;
    logic signed [mm5_pkg::PROD_W-1:0]  typed_val = '0;
    product_t                           pending_products [$];
    load_row_t                          load_table [0:2];

    int                                 mismatch_count = 0;
    int                                 results_taken = 0;
    bit                                 tail_quiet = 1'b0;
    bit                                 stall_done = 1'b0;

    matrix_multiply_5x5 dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row_index     (m_row_index),
        .m_col_index     (m_col_index),
        .m_product_value (m_product_value),
        .m_last_result   (m_last_result)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic signed [mm5_pkg::PROD_W-1:0] row_col_sum(input int i,
                                                                       input int j);
        longint acc = 0;
        for (int k = 0; k < mm5_pkg::DIM; k++) begin
            acc += longint'(store_a[i*mm5_pkg::DIM+k]) *
                   longint'(store_b[k*mm5_pkg::DIM+j]);
        end
        return acc[mm5_pkg::PROD_W-1:0];
    endfunction

    task automatic predict_products(input logic signed [mm5_pkg::ELEM_W-1:0] v);
        product_t p;
        if (load_pos == 0) begin
            load_typed     = typed_on;
            load_typed_val = typed_val;
        end
        if (load_pos < mm5_pkg::CELLS) begin
            store_a[load_pos] = v;
        end else begin
            store_b[load_pos-mm5_pkg::CELLS] = v;
        end
        load_pos++;
        if (load_pos == 2 * mm5_pkg::CELLS) begin
            load_pos = 0;
            for (int i = 0; i < mm5_pkg::DIM; i++) begin
                for (int j = 0; j < mm5_pkg::DIM; j++) begin
                    p.row     = mm5_pkg::ROW_W'(i);
                    p.col     = mm5_pkg::ROW_W'(j);
                    p.product = load_typed ? load_typed_val : row_col_sum(i, j);
                    p.last    = (i == mm5_pkg::DIM - 1) && (j == mm5_pkg::DIM - 1);
                    pending_products.push_back(p);
                end
            end
        end
    endtask

    task automatic check_product();
        product_t want;
        results_taken++;
        if (pending_products.size() == 0) begin
            flag_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                    m_row_index, m_col_index, m_product_value));
        end else begin
            want = pending_products.pop_front();
            if (m_row_index !== want.row)
                flag_mismatch($sformatf("row_index got %0d want %0d", m_row_index, want.row));
            if (m_col_index !== want.col)
                flag_mismatch($sformatf("col_index got %0d want %0d", m_col_index, want.col));
            if (m_product_value !== want.product)
                flag_mismatch($sformatf("product_value [%0d][%0d] got %0d want %0d",
                                        want.row, want.col, m_product_value, want.product));
            if (m_last_result !== want.last)
                flag_mismatch($sformatf("last_result [%0d][%0d] got %0b want %0b",
                                        want.row, want.col, m_last_result, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_products(s_element_value);
        end
        if (aresetn && m_valid && m_ready) begin
            check_product();
        end
    end

    function automatic logic signed [mm5_pkg::ELEM_W-1:0] random_element(input int mode);
        int pick;
        int small_val;
        pick = (mode == 0) ? 5 : (mode == 2) ? 2 : int'($urandom_range(0, 5));
        small_val = int'($urandom_range(0, 16)) - 8;
        case (pick)
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return small_val[mm5_pkg::ELEM_W-1:0];
            default: return mm5_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_element(input logic signed [mm5_pkg::ELEM_W-1:0] v);
        if (!tail_quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_element_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // receiver: random stall bursts plus one long hold-off while results are pending
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!stall_done && results_taken >= STALL_AFTER) begin
                stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(posedge aclk);
            end else if (!tail_quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic signed [mm5_pkg::ELEM_W-1:0] fill;
        int mode;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_element_value = '0;
        load_table[0] = '{16'sh8000, 16'sh8000, 1'b0, 1'b1, 35'sd5368709120};
        load_table[1] = '{16'sh7fff, 16'sh8000, 1'b0, 1'b1, -35'sd5368545280};
        load_table[2] = '{16'sh7fff, 16'sh8000, 1'b1, 1'b0, 35'sd0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extreme constant fills, then alternating extremes
        foreach (load_table[r]) begin
            typed_on  = load_table[r].typed;
            typed_val = load_table[r].product;
            for (int k = 0; k < 2 * mm5_pkg::CELLS; k++) begin
                fill = (k < mm5_pkg::CELLS) ? load_table[r].a_fill : load_table[r].b_fill;
                send_element((load_table[r].alternate && k[0]) ? ~fill : fill);
            end
        end

        typed_on = 1'b0;
        for (int r = 0; r < RAND_LOADS; r++) begin
            if (r == RAND_LOADS - 1) begin
                tail_quiet = 1'b1;
            end
            mode = int'($urandom_range(0, 2));
            for (int k = 0; k < 2 * mm5_pkg::CELLS; k++) begin
                send_element(random_element(mode));
            end
        end
        s_valid <= 1'b0;

        // let the monitor see the final transaction before draining
        @(posedge aclk);
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #600us;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mm5_pkg.sv
rtl/core/mm5_ram.sv
rtl/core/mm5_mac.sv
rtl/core/matrix_multiply_5x5.sv
tb/sv/matrix_multiply_5x5_tb.sv
